/* design/user_activity_idle_detector_top_macros.svh */
// Assertion macros for the user activity idle detector checker.
// No dependencies; included by the checker file.
`ifndef USER_ACTIVITY_IDLE_DETECTOR_TOP_MACROS_SVH
`define USER_ACTIVITY_IDLE_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define UAID_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define UAID_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/uaid_pkg.sv */
// Shared types and constants of the user activity idle detector.
// No dependencies; compile first.
package uaid_pkg;

  localparam int OPCODE_W   = 3;
  localparam int TIME_W     = 40;
  localparam int STAMP_W    = 41;
  localparam int DIFF_W     = 42;
  localparam int MS_W       = 24;
  localparam int SENS_W     = 16;
  localparam int POS_W      = 16;
  localparam int SHIFT_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [DIFF_W-1:0] MS_PER_SECOND = DIFF_W'(1000);

  typedef enum logic [OPCODE_W-1:0] {
    OP_MOUSE,
    OP_BUTTON,
    OP_KEY,
    OP_QUERY,
    OP_SUSPEND,
    OP_RESUME,
    OP_FORCE_IDLE,
    OP_SHIFT
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NOISE,
    MODE_ACTIVE,
    MODE_SUSPENDED
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_GAP    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVITY     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY  = CFG_IDX_W'(3);

  typedef struct packed {
    logic [MS_W-1:0]   noise_gap_ms;
    logic [MS_W-1:0]   activity_time_ms;
    logic [MS_W-1:0]   idle_timeout_ms;
    logic [SENS_W-1:0] move_sensitivity;
    logic              wr_strobe;
  } cfg_t;

  typedef struct packed {
    opcode_t                   opcode;
    logic [TIME_W-1:0]         now_ms;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   wheel_step;
    logic                      btn_down;
    logic signed [SHIFT_W-1:0] shift_seconds;
  } item_t;

  typedef struct packed {
    mode_t act_mode;
    logic  action_reported;
  } result_t;

endpackage

/* design/uaid_in_if.sv */
// Input event channel of the user activity idle detector.
// Depends on uaid_pkg.
interface uaid_in_if import uaid_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OPCODE_W-1:0]       opcode;
  logic [TIME_W-1:0]         now_ms;
  logic signed [POS_W-1:0]   pos_x;
  logic signed [POS_W-1:0]   pos_y;
  logic signed [POS_W-1:0]   wheel_step;
  logic                      btn_down;
  logic signed [SHIFT_W-1:0] shift_seconds;

  modport source (
    output valid, opcode, now_ms, pos_x, pos_y, wheel_step, btn_down, shift_seconds,
    input  ready
  );
  modport sink (
    input  valid, opcode, now_ms, pos_x, pos_y, wheel_step, btn_down, shift_seconds,
    output ready
  );
endinterface

/* design/uaid_out_if.sv */
// Result channel of the user activity idle detector.
// Depends on uaid_pkg.
interface uaid_out_if import uaid_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] act_mode;
  logic       action_reported;

  modport source (output valid, act_mode, action_reported, input ready);
  modport sink (input valid, act_mode, action_reported, output ready);
endinterface

/* design/uaid_cfg_if.sv */
// Register write channel of the user activity idle detector.
// Depends on uaid_pkg.
interface uaid_cfg_if import uaid_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/uaid_cfg_regs.sv */
// Configuration registers of the user activity idle detector.
// Depends on uaid_pkg and uaid_cfg_if.
module uaid_cfg_regs import uaid_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  uaid_cfg_if.sink   cfg_ch,
  output cfg_t       cfg
);

  logic [MS_W-1:0]   noise_gap_r, noise_gap_nxt;
  logic [MS_W-1:0]   activity_r, activity_nxt;
  logic [MS_W-1:0]   idle_timeout_r, idle_timeout_nxt;
  logic [SENS_W-1:0] sens_r, sens_nxt;
  logic              wr_strobe_r, wr_strobe_nxt;
  logic              wr;

  assign cfg_ch.ready = rst_n;
  assign wr = cfg_ch.valid && cfg_ch.ready;

  always_comb begin
    noise_gap_nxt    = noise_gap_r;
    activity_nxt     = activity_r;
    idle_timeout_nxt = idle_timeout_r;
    sens_nxt         = sens_r;
    wr_strobe_nxt    = 1'b0;
    if (wr) begin
      case (cfg_ch.index)
        CFG_NOISE_GAP: begin
          noise_gap_nxt = cfg_ch.data;
          wr_strobe_nxt = 1'b1;
        end
        CFG_ACTIVITY: begin
          activity_nxt  = cfg_ch.data;
          wr_strobe_nxt = 1'b1;
        end
        CFG_IDLE_TIMEOUT: begin
          idle_timeout_nxt = cfg_ch.data;
          wr_strobe_nxt    = 1'b1;
        end
        CFG_SENSITIVITY: begin
          sens_nxt      = cfg_ch.data[SENS_W-1:0];
          wr_strobe_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_gap_r    <= MS_W'(1000);
      activity_r     <= MS_W'(2000);
      idle_timeout_r <= MS_W'(5000);
      sens_r         <= SENS_W'(3);
      wr_strobe_r    <= 1'b0;
    end else begin
      noise_gap_r    <= noise_gap_nxt;
      activity_r     <= activity_nxt;
      idle_timeout_r <= idle_timeout_nxt;
      sens_r         <= sens_nxt;
      wr_strobe_r    <= wr_strobe_nxt;
    end
  end

  assign cfg = '{
    noise_gap_ms:     noise_gap_r,
    activity_time_ms: activity_r,
    idle_timeout_ms:  idle_timeout_r,
    move_sensitivity: sens_r,
    wr_strobe:        wr_strobe_r
  };

endmodule

/* design/uaid_core.sv */
// Activity state and single-pass evaluation of one event word.
// Depends on uaid_pkg.
module uaid_core import uaid_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  mode_t                   mode_r, mode_nxt;
  logic [STAMP_W-1:0]      burst_r, burst_nxt;
  logic [STAMP_W-1:0]      last_r, last_nxt;
  logic signed [POS_W-1:0] px_r, px_nxt;
  logic signed [POS_W-1:0] py_r, py_nxt;
  logic                    held_r, held_nxt;
  logic                    action;

  logic signed [POS_W:0]   dx, dy;
  logic [POS_W:0]          adx, ady;
  logic                    moved;
  logic [STAMP_W-1:0]      now_ext;
  logic signed [DIFF_W-1:0] gap_last, gap_burst;
  logic                    noise_over, burst_done, idle_over;
  logic [DIFF_W-1:0]       shift_ext, shift_prod;
  logic [STAMP_W-1:0]      shift_ms;

  assign dx  = {item.pos_x[POS_W-1], item.pos_x} - {px_r[POS_W-1], px_r};
  assign dy  = {item.pos_y[POS_W-1], item.pos_y} - {py_r[POS_W-1], py_r};
  assign adx = dx[POS_W] ? (POS_W+1)'(-dx) : (POS_W+1)'(dx);
  assign ady = dy[POS_W] ? (POS_W+1)'(-dy) : (POS_W+1)'(dy);
  assign moved = (adx >= {1'b0, cfg.move_sensitivity})
              || (ady >= {1'b0, cfg.move_sensitivity})
              || (item.wheel_step != '0) || held_r;

  assign now_ext   = {1'b0, item.now_ms};
  assign gap_last  = $signed({2'b00, item.now_ms}) - $signed({last_r[STAMP_W-1], last_r});
  assign gap_burst = $signed({2'b00, item.now_ms}) - $signed({burst_r[STAMP_W-1], burst_r});
  assign noise_over = gap_last > $signed({{(DIFF_W-MS_W){1'b0}}, cfg.noise_gap_ms});
  assign idle_over  = gap_last > $signed({{(DIFF_W-MS_W){1'b0}}, cfg.idle_timeout_ms});
  assign burst_done = gap_burst >= $signed({{(DIFF_W-MS_W){1'b0}}, cfg.activity_time_ms});

  assign shift_ext  = {{(DIFF_W-SHIFT_W){item.shift_seconds[SHIFT_W-1]}}, item.shift_seconds};
  assign shift_prod = (shift_ext << 10) - (shift_ext << 5) + (shift_ext << 3);
  assign shift_ms   = shift_prod[STAMP_W-1:0];

  always_comb begin
    mode_nxt  = mode_r;
    burst_nxt = burst_r;
    last_nxt  = last_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    held_nxt  = held_r;
    action    = 1'b0;
    case (item.opcode)
      OP_MOUSE: begin
        px_nxt = item.pos_x;
        py_nxt = item.pos_y;
        action = moved;
      end
      OP_BUTTON: begin
        held_nxt = item.btn_down;
        action   = item.btn_down;
      end
      OP_KEY: action = 1'b1;
      OP_QUERY: begin
        if (mode_r == MODE_ACTIVE && idle_over) mode_nxt = MODE_IDLE;
      end
      OP_SUSPEND: mode_nxt = MODE_SUSPENDED;
      OP_RESUME:  mode_nxt = MODE_IDLE;
      OP_FORCE_IDLE: begin
        if (mode_r != MODE_SUSPENDED) begin
          mode_nxt = MODE_IDLE;
          last_nxt = '0;
        end
      end
      OP_SHIFT: begin
        last_nxt  = last_r + shift_ms;
        burst_nxt = burst_r + shift_ms;
      end
      default: ;
    endcase

    if (action) begin
      case (mode_r)
        MODE_IDLE: begin
          burst_nxt = now_ext;
          mode_nxt  = (cfg.activity_time_ms == '0) ? MODE_ACTIVE : MODE_NOISE;
        end
        MODE_NOISE: begin
          if (noise_over) burst_nxt = now_ext;
          else if (burst_done) mode_nxt = MODE_ACTIVE;
        end
        default: ;
      endcase
      last_nxt = now_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      burst_r <= '0;
      last_r  <= '0;
      px_r    <= '0;
      py_r    <= '0;
      held_r  <= 1'b0;
    end else begin
      if (cfg.wr_strobe) begin
        mode_r <= MODE_IDLE;
      end else if (en) begin
        mode_r <= mode_nxt;
      end
      if (en) begin
        burst_r <= burst_nxt;
        last_r  <= last_nxt;
        px_r    <= px_nxt;
        py_r    <= py_nxt;
        held_r  <= held_nxt;
      end
    end
  end

  assign res = '{act_mode: mode_nxt, action_reported: action};

endmodule

/* design/user_activity_idle_detector_top.sv */
// User activity idle detector: one result word per event word, giving the
// activity mode after the event and whether it counted as a user action.
// An event word is taken into an input register, evaluated in one pass by
// the core against the stored activity state, and its result is held in a
// result register; a new word is taken every cycle unless the result side
// stalls, and each result passes from the input register through the core
// into the result register before it can be taken. Out of reset, the input
// side stalls only while the result register is full and not taken.
// Register writes are taken at any time out of reset and return the mode to
// idle through the registered write strobe of the configuration registers.
// Depends on uaid_pkg, the channel interfaces, uaid_cfg_regs and uaid_core.
module user_activity_idle_detector_top import uaid_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  uaid_in_if.sink    in_ch,
  uaid_out_if.source out_ch,
  uaid_cfg_if.sink   cfg_ch
);

  cfg_t    cfg;
  item_t   s1_item_r;
  logic    s1_valid_r, s1_valid_nxt;
  result_t out_res_r;
  logic    out_valid_r, out_valid_nxt;
  result_t res;
  logic    advance;
  logic    in_acc;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = rst_n && (!s1_valid_r || advance);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt  = in_acc ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= '{
        opcode:        opcode_t'(in_ch.opcode),
        now_ms:        in_ch.now_ms,
        pos_x:         in_ch.pos_x,
        pos_y:         in_ch.pos_y,
        wheel_step:    in_ch.wheel_step,
        btn_down:      in_ch.btn_down,
        shift_seconds: in_ch.shift_seconds
      };
    end
    if (advance) out_res_r <= res;
  end

  uaid_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  uaid_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_ch.valid           = out_valid_r;
  assign out_ch.act_mode        = out_res_r.act_mode;
  assign out_ch.action_reported = out_res_r.action_reported;

endmodule

/* design/uaid_checker.sv */
// Port-level checks of the user activity idle detector, bound to the top.
// Depends on uaid_pkg, the channel interfaces and the assertion macros.
`include "user_activity_idle_detector_top_macros.svh"

module uaid_checker import uaid_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  uaid_in_if.sink in_ch,
  uaid_out_if.source out_ch
);

  logic       in_acc;
  logic       in_stall;
  logic       out_stall;
  logic [2:0] out_word;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign in_stall  = in_ch.valid && !in_ch.ready;
  assign out_stall = out_ch.valid && !out_ch.ready;
  assign out_word  = {out_ch.act_mode, out_ch.action_reported};

  `UAID_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_ch.valid && $stable(out_word), "result word changed while stalled")
  `UAID_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_stall, "input stalled with result side free")
  `UAID_ASSERT_IMP(a_rise_latency, clk, rst_n, $rose(out_ch.valid), $past(in_acc, 2), "result word without accepted event")
  `UAID_ASSERT_IMP(a_action_not_idle, clk, rst_n, out_ch.valid && out_ch.action_reported, out_ch.act_mode != MODE_IDLE, "action reported with idle mode")

endmodule

bind user_activity_idle_detector_top uaid_checker u_chk (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

/* test/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for user_activity_idle_detector_top: random and directed event words
// against an in-bench activity predictor, with register writes between phases.
// Depends on uaid_pkg, the three channel interfaces and the top level.
module tb;
  import uaid_pkg::*;

  localparam int     RESET_CYCLES    = 12;
  localparam int     MAX_GAP         = 18;
  localparam int     HOLD_CYCLES     = 300;
  localparam int     SETTLE_CYCLES   = 4;
  localparam int     END_CYCLES      = 10;
  localparam int     PHASES          = 7;
  localparam int     ITEMS_PER_PHASE = 180;
  localparam int     FLOOD_ITEMS     = 40;
  localparam int     CYCLE_LIMIT     = 400000;
  localparam int     ERROR_PRINTS    = 100;
  localparam longint MS_PER_S        = longint'(MS_PER_SECOND);
  localparam longint TIME_MASK       = (longint'(1) << TIME_W) - 1;

  class activity_predictor;
    logic [MS_W-1:0]           noise_gap;
    logic [MS_W-1:0]           activity_time;
    logic [MS_W-1:0]           idle_timeout;
    logic [SENS_W-1:0]         sensitivity;
    mode_t                     mode;
    logic signed [STAMP_W-1:0] burst_start;
    logic signed [STAMP_W-1:0] last_action;
    logic signed [POS_W-1:0]   last_x;
    logic signed [POS_W-1:0]   last_y;
    logic                      button_down;
    result_t                   awaited[$];
    int                        words_seen;
    int                        errors;

    function new();
      noise_gap     = MS_W'(1000);
      activity_time = MS_W'(2000);
      idle_timeout  = MS_W'(5000);
      sensitivity   = SENS_W'(3);
      mode          = MODE_IDLE;
      burst_start   = '0;
      last_action   = '0;
      last_x        = '0;
      last_y        = '0;
      button_down   = 1'b0;
      words_seen    = 0;
      errors        = 0;
    endfunction

    task report(string what);
      errors++;
      if (errors <= ERROR_PRINTS) $display("mismatch: %s", what);
    endtask

    function int pending();
      return awaited.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_NOISE_GAP:    noise_gap = data;
        CFG_ACTIVITY:     activity_time = data;
        CFG_IDLE_TIMEOUT: idle_timeout = data;
        CFG_SENSITIVITY:  sensitivity = data[SENS_W-1:0];
        default: return;
      endcase
      mode = MODE_IDLE;
    endfunction

    function void take_action(longint now);
      case (mode)
        MODE_IDLE: begin
          burst_start = STAMP_W'(now);
          mode = (activity_time == 0) ? MODE_ACTIVE : MODE_NOISE;
        end
        MODE_NOISE: begin
          if (now - longint'(last_action) > longint'(noise_gap))
            burst_start = STAMP_W'(now);
          else if (now - longint'(burst_start) >= longint'(activity_time))
            mode = MODE_ACTIVE;
        end
        default: ;
      endcase
      last_action = STAMP_W'(now);
    endfunction

    function void note_event(item_t it);
      longint  now;
      longint  shift_ms;
      int      dx;
      int      dy;
      logic    acted;
      result_t r;
      now   = longint'(it.now_ms);
      acted = 1'b0;
      case (it.opcode)
        OP_MOUSE: begin
          dx = int'(it.pos_x) - int'(last_x);
          dy = int'(it.pos_y) - int'(last_y);
          if (dx < 0) dx = -dx;
          if (dy < 0) dy = -dy;
          last_x = it.pos_x;
          last_y = it.pos_y;
          acted = (dx >= int'(sensitivity)) || (dy >= int'(sensitivity)) ||
                  (it.wheel_step != 0) || button_down;
        end
        OP_BUTTON: begin
          button_down = it.btn_down;
          acted = button_down;
        end
        OP_KEY: acted = 1'b1;
        OP_QUERY: begin
          if (mode == MODE_ACTIVE && now - longint'(last_action) > longint'(idle_timeout))
            mode = MODE_IDLE;
        end
        OP_SUSPEND: mode = MODE_SUSPENDED;
        OP_RESUME: mode = MODE_IDLE;
        OP_FORCE_IDLE: begin
          if (mode != MODE_SUSPENDED) begin
            mode = MODE_IDLE;
            last_action = '0;
          end
        end
        default: begin
          shift_ms    = longint'(it.shift_seconds) * MS_PER_S;
          last_action = STAMP_W'(longint'(last_action) + shift_ms);
          burst_start = STAMP_W'(longint'(burst_start) + shift_ms);
        end
      endcase
      if (acted) take_action(now);
      r.act_mode        = mode;
      r.action_reported = acted;
      awaited.push_back(r);
    endfunction

    task check_word(logic [1:0] state, logic acted);
      result_t want;
      words_seen++;
      if (awaited.size() == 0) begin
        report($sformatf("word %0d arrived with nothing awaited", words_seen));
        return;
      end
      want = awaited.pop_front();
      if (state !== want.act_mode)
        report($sformatf("word %0d: activity mode %0d, expected %0d",
                         words_seen, state, want.act_mode));
      if (acted !== want.action_reported)
        report($sformatf("word %0d: action flag %0b, expected %0b",
                         words_seen, acted, want.action_reported));
    endtask
  endclass

  logic clk;
  logic rst_n;

  uaid_in_if  in_if();
  uaid_out_if out_if();
  uaid_cfg_if cfg_if();

  user_activity_idle_detector_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  activity_predictor       sb;
  bit                      sender_eager;
  bit                      sink_eager;
  bit                      flooding;
  bit                      hold_req;
  bit                      offering;
  int                      items_sent;
  longint                  clock_ms;
  logic signed [POS_W-1:0] mouse_x;
  logic signed [POS_W-1:0] mouse_y;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic item_t random_fields(opcode_t op, logic [TIME_W-1:0] now);
    item_t it;
    it.opcode        = op;
    it.now_ms        = now;
    it.pos_x         = POS_W'($urandom);
    it.pos_y         = POS_W'($urandom);
    it.wheel_step    = POS_W'($urandom);
    it.btn_down      = 1'($urandom);
    it.shift_seconds = SHIFT_W'($urandom);
    return it;
  endfunction

  function automatic item_t mouse_at(logic [TIME_W-1:0] now, int x, int y, int wheel);
    item_t it;
    it            = random_fields(OP_MOUSE, now);
    it.pos_x      = POS_W'(x);
    it.pos_y      = POS_W'(y);
    it.wheel_step = POS_W'(wheel);
    mouse_x       = it.pos_x;
    mouse_y       = it.pos_y;
    return it;
  endfunction

  function automatic logic [TIME_W-1:0] advance(longint gap_ms);
    clock_ms = (clock_ms + gap_ms) & TIME_MASK;
    return TIME_W'(clock_ms);
  endfunction

  function automatic logic [MS_W-1:0] pick_threshold();
    case ($urandom_range(0, 2))
      0: return sb.noise_gap;
      1: return sb.activity_time;
      default: return sb.idle_timeout;
    endcase
  endfunction

  function automatic longint gap_near(logic [MS_W-1:0] limit);
    case ($urandom_range(0, 5))
      0: return 0;
      1, 2: return longint'($urandom_range(0, limit));
      3: return longint'(limit) + longint'($urandom_range(0, 4)) - 2;
      4: return longint'($urandom_range(0, 3 * limit + 10));
      default: return -longint'($urandom_range(0, 50));
    endcase
  endfunction

  task automatic send_event(item_t it);
    int gap;
    if ($urandom_range(0, 39) == 0) sender_eager = !sender_eager;
    gap = (sender_eager || flooding) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0 && offering) begin
      in_if.valid <= 1'b0;
      offering = 1'b0;
    end
    repeat (gap) @(posedge clk);
    in_if.valid         <= 1'b1;
    in_if.opcode        <= it.opcode;
    in_if.now_ms        <= it.now_ms;
    in_if.pos_x         <= it.pos_x;
    in_if.pos_y         <= it.pos_y;
    in_if.wheel_step    <= it.wheel_step;
    in_if.btn_down      <= it.btn_down;
    in_if.shift_seconds <= it.shift_seconds;
    offering = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    sb.note_event(it);
    items_sent++;
  endtask

  task automatic drain();
    if (offering) begin
      in_if.valid <= 1'b0;
      offering = 1'b0;
    end
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_settings(logic [CFG_DATA_W-1:0] gap, logic [CFG_DATA_W-1:0] act,
                                logic [CFG_DATA_W-1:0] idle, logic [CFG_DATA_W-1:0] sens);
    write_reg(CFG_NOISE_GAP, gap);
    write_reg(CFG_ACTIVITY, act);
    write_reg(CFG_IDLE_TIMEOUT, idle);
    write_reg(CFG_SENSITIVITY, sens);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic reconfigure(int phase);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    case (phase)
      2: apply_settings('1, '1, '1, '1);
      3: apply_settings('0, '0, '0, '0);
      4: apply_settings(CFG_DATA_W'(50), CFG_DATA_W'(200), CFG_DATA_W'(400), CFG_DATA_W'(2));
      5: begin
        write_reg(CFG_IDX_W'(CFG_SENSITIVITY + 1 + $urandom_range(0, 3)),
                  CFG_DATA_W'($urandom));
        cfg_if.valid <= 1'b0;
      end
      6: apply_settings(CFG_DATA_W'($urandom_range(0, 3000)),
                        CFG_DATA_W'($urandom_range(0, 6000)),
                        CFG_DATA_W'($urandom_range(0, 9000)),
                        CFG_DATA_W'($urandom_range(0, 40)));
      7: apply_settings(CFG_DATA_W'(1000), CFG_DATA_W'(0), CFG_DATA_W'(3000), CFG_DATA_W'(1));
      default: ;
    endcase
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_op(opcode_t op, longint gap_ms, bit lively);
    item_t it;
    int    step;
    int    off_a;
    int    off_b;
    it = random_fields(op, advance(gap_ms));
    case (op)
      OP_MOUSE: begin
        if ($urandom_range(0, 7) != 0) begin
          step = lively ? int'(sb.sensitivity) + $urandom_range(0, 2) :
                 (sb.sensitivity == 0) ? 0 : $urandom_range(0, sb.sensitivity - 1);
          off_a = $urandom_range(0, 1) ? step : -step;
          off_b = $urandom_range(0, step);
          if ($urandom_range(0, 1)) off_b = -off_b;
          if ($urandom_range(0, 1)) begin
            it.pos_x = POS_W'(int'(mouse_x) + off_a);
            it.pos_y = POS_W'(int'(mouse_y) + off_b);
          end else begin
            it.pos_x = POS_W'(int'(mouse_x) + off_b);
            it.pos_y = POS_W'(int'(mouse_y) + off_a);
          end
          if ($urandom_range(0, 5) != 0) it.wheel_step = '0;
        end
        mouse_x = it.pos_x;
        mouse_y = it.pos_y;
      end
      OP_BUTTON: if (lively) it.btn_down = 1'b1;
      OP_SHIFT: begin
        if ($urandom_range(0, 3) != 0)
          it.shift_seconds = SHIFT_W'(int'($urandom_range(0, 20)) - 10);
      end
      default: ;
    endcase
    send_event(it);
  endtask

  task automatic random_episode();
    int              kind;
    logic [MS_W-1:0] span;
    kind = $urandom_range(0, 9);
    span = sb.noise_gap;
    if (kind < 6) begin
      repeat ($urandom_range(2, 12))
        send_op(opcode_t'($urandom_range(OP_MOUSE, OP_KEY)),
                $urandom_range(0, 1) ? longint'($urandom_range(span / 2, span)) :
                                       longint'($urandom_range(0, span)),
                $urandom_range(0, 4) != 0);
      repeat ($urandom_range(0, 2)) send_op(OP_QUERY, gap_near(sb.idle_timeout), 1'b0);
    end else if (kind < 8) begin
      if ($urandom_range(0, 9) == 0) clock_ms = {$urandom, $urandom} & TIME_MASK;
      repeat ($urandom_range(1, 6))
        send_op(opcode_t'($urandom_range(OP_MOUSE, OP_SHIFT)), gap_near(pick_threshold()),
                1'($urandom));
    end else begin
      send_op(opcode_t'($urandom_range(OP_SUSPEND, OP_SHIFT)), gap_near(span), 1'b0);
      repeat ($urandom_range(0, 3)) send_op(OP_KEY, gap_near(span), 1'b1);
      send_op(opcode_t'($urandom_range(OP_QUERY, OP_SHIFT)), gap_near(pick_threshold()), 1'b0);
    end
  endtask

  task automatic run_random(int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) random_episode();
  endtask

  task automatic run_directed();
    item_t it;
    send_event(mouse_at(10000, 2, -2, 0));
    send_event(mouse_at(10000, -32768, 32767, 0));
    send_event(random_fields(OP_KEY, 10500));
    it = random_fields(OP_BUTTON, 11000);
    it.btn_down = 1'b1;
    send_event(it);
    send_event(mouse_at(11900, -32768, 32767, 0));
    it = random_fields(OP_BUTTON, 12000);
    it.btn_down = 1'b0;
    send_event(it);
    send_event(mouse_at(13000, -32768, 32767, 32767));
    send_event(mouse_at(13001, -32768, 32767, -32768));
    send_event(random_fields(OP_QUERY, 18001));
    send_event(random_fields(OP_QUERY, 18002));
    send_event(random_fields(OP_KEY, 18002));
    send_event(random_fields(OP_KEY, 19003));
    send_event(random_fields(OP_SUSPEND, 19003));
    send_event(random_fields(OP_KEY, 19100));
    send_event(random_fields(OP_FORCE_IDLE, 19100));
    send_event(random_fields(OP_QUERY, 99999));
    send_event(random_fields(OP_RESUME, 99999));
    send_event(random_fields(OP_RESUME, 99999));
    send_event(random_fields(OP_KEY, '1));
    send_event(random_fields(OP_FORCE_IDLE, '1));
    it = random_fields(OP_SHIFT, 0);
    it.shift_seconds = 32'sh7FFF_FFFF;
    send_event(it);
    it.shift_seconds = 32'sh8000_0000;
    send_event(it);
    send_event(random_fields(OP_KEY, 500));
    send_event(random_fields(OP_KEY, 0));
    send_event(random_fields(OP_QUERY, 0));
    clock_ms = 0;
  endtask

  initial begin : result_sink
    int stall;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_eager = !sink_eager;
      stall = sink_eager ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      sb.check_word(out_if.act_mode, out_if.action_reported);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    sb = new();
    rst_n               <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.opcode        <= '0;
    in_if.now_ms        <= '0;
    in_if.pos_x         <= '0;
    in_if.pos_y         <= '0;
    in_if.wheel_step    <= '0;
    in_if.btn_down      <= 1'b0;
    in_if.shift_seconds <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= '0;
    cfg_if.data         <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int phase = 1; phase <= PHASES; phase++) begin
      reconfigure(phase);
      if (phase == 2) begin
        // hold the sink off while words pour in, so the input side backs up
        hold_req = 1'b1;
        flooding = 1'b1;
        run_random(FLOOD_ITEMS);
        flooding = 1'b0;
      end
      run_random(ITEMS_PER_PHASE / 2);
      if (phase == 5) drain();
      run_random(ITEMS_PER_PHASE / 2);
    end
    drain();
    repeat (END_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+design
design/uaid_pkg.sv
design/uaid_in_if.sv
design/uaid_out_if.sv
design/uaid_cfg_if.sv
design/uaid_cfg_regs.sv
design/uaid_core.sv
design/user_activity_idle_detector_top.sv
design/uaid_checker.sv
test/tb.sv
